// ----- hw/rtl/edd_pkg.sv -----
// package for the error diffusion dither block
// shared constants, default parameters and control structs; no dependencies
package edd_pkg;

  localparam int unsigned MaxLineDef  = 1024;
  localparam int unsigned FracBitsDef = 4;
  localparam int unsigned PixW        = 8;
  localparam int unsigned CfgW        = 11;
  localparam logic [CfgW-1:0] LenRst  = CfgW'(1024);
  localparam int unsigned OutDepth    = 4;

  typedef struct packed {
    logic frame_start;
    logic last;
  } edd_ctl_t;

  typedef struct packed {
    logic dot;
    logic line_end;
  } edd_res_t;

endpackage

// ----- hw/rtl/edd_if.sv -----
// valid/ready stream interfaces for pixel words in and dot words out
// depends on edd_pkg
interface edd_pix_if;
  import edd_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;
  logic            frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface edd_dot_if;
  logic valid;
  logic ready;
  logic dot;
  logic line_end;

  modport source (output valid, output dot, output line_end, input ready);
  modport sink   (input valid, input dot, input line_end, output ready);
endinterface

// ----- hw/rtl/edd_row_store.sv -----
// row error memory with one-entry write buffer, fill count and read forwarding
// depends on edd_pkg
module edd_row_store #(
  parameter int unsigned DEPTH = edd_pkg::MaxLineDef,
  parameter int unsigned ERR_W = edd_pkg::FracBitsDef + 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr_i,
  input  logic                            a_en_i,
  input  logic [$clog2(DEPTH)-1:0]        a_addr_i,
  input  logic signed [ERR_W-1:0]         a_data_i,
  input  logic                            b_en_i,
  input  logic [$clog2(DEPTH)-1:0]        b_addr_i,
  input  logic signed [ERR_W-1:0]         b_data_i,
  output logic signed [ERR_W-1:0]         above_o
);
  import edd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_FWD,
    SRC_ZERO
  } edd_src_e;

  logic signed [ERR_W-1:0] mem_q [DEPTH];
  logic signed [ERR_W-1:0] rd_data_q;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [ERR_W-1:0] wdata;

  logic                    buf_vld_d, buf_vld_q;
  logic [AW-1:0]           buf_addr_d, buf_addr_q;
  logic signed [ERR_W-1:0] buf_data_d, buf_data_q;

  logic [CW-1:0]           fill_d, fill_q;
  logic [CW-1:0]           a_cnt, b_cnt;

  edd_src_e                src_d, src_q;
  logic signed [ERR_W-1:0] fwd_data_d, fwd_data_q;

  // one write port: the buffer only ever holds the end-of-line write
  always_comb begin
    we         = 1'b0;
    waddr      = a_addr_i;
    wdata      = a_data_i;
    buf_vld_d  = 1'b0;
    buf_addr_d = b_addr_i;
    buf_data_d = b_data_i;
    if (a_en_i) begin
      we        = 1'b1;
      buf_vld_d = b_en_i;
    end else if (buf_vld_q) begin
      we        = 1'b1;
      waddr     = buf_addr_q;
      wdata     = buf_data_q;
      buf_vld_d = b_en_i;
    end else if (b_en_i) begin
      we    = 1'b1;
      waddr = b_addr_i;
      wdata = b_data_i;
    end
  end

  // entries at or above the fill count were never written and read as zero
  assign a_cnt = CW'(a_addr_i) + CW'(1);
  assign b_cnt = CW'(b_addr_i) + CW'(1);

  always_comb begin
    fill_d = fill_q;
    if (a_en_i && (a_cnt > fill_d)) begin
      fill_d = a_cnt;
    end
    if (b_en_i && (b_cnt > fill_d)) begin
      fill_d = b_cnt;
    end
  end

  always_comb begin
    fwd_data_d = wdata;
    if (buf_vld_d && (buf_addr_d == rd_addr_i)) begin
      src_d      = SRC_FWD;
      fwd_data_d = buf_data_d;
    end else if (we && (waddr == rd_addr_i)) begin
      src_d = SRC_FWD;
    end else if (CW'(rd_addr_i) >= fill_q) begin
      src_d = SRC_ZERO;
    end else begin
      src_d = SRC_MEM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_vld_q <= 1'b0;
      fill_q    <= '0;
      src_q     <= SRC_ZERO;
    end else begin
      buf_vld_q <= buf_vld_d;
      fill_q    <= fill_d;
      src_q     <= src_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_addr_q <= buf_addr_d;
    buf_data_q <= buf_data_d;
    fwd_data_q <= fwd_data_d;
  end

  always_comb begin
    case (src_q)
      SRC_FWD:  above_o = fwd_data_q;
      SRC_ZERO: above_o = '0;
      default:  above_o = rd_data_q;
    endcase
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) a_en_i |-> !buf_vld_q)
    else $error("row write collides with a held end-of-line write");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_d >= fill_q)
    else $error("fill count went down");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   buf_vld_q |-> (CW'(buf_addr_q) < fill_q))
    else $error("buffered write lies above the fill count");
`endif

endmodule

// ----- hw/rtl/edd_diffuse.sv -----
// threshold and error split for one pixel, holding the carry and pending sums
// depends on edd_pkg
module edd_diffuse #(
  parameter int unsigned DEPTH     = edd_pkg::MaxLineDef,
  parameter int unsigned FRAC_BITS = edd_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  edd_pkg::edd_ctl_t                 ctl_i,
  input  logic [$clog2(DEPTH)-1:0]          col_i,
  input  logic [edd_pkg::PixW-1:0]          pixel_i,
  input  logic signed [FRAC_BITS+9:0]       above_i,
  output logic                              dot_o,
  output logic                              a_en_o,
  output logic [$clog2(DEPTH)-1:0]          a_addr_o,
  output logic signed [FRAC_BITS+9:0]       a_data_o,
  output logic                              b_en_o,
  output logic [$clog2(DEPTH)-1:0]          b_addr_o,
  output logic signed [FRAC_BITS+9:0]       b_data_o
);
  import edd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned EW = FRAC_BITS + 10;
  localparam int unsigned XW = EW + 2;
  localparam int unsigned PW = EW + 4;
  localparam logic signed [XW-1:0] ErrMax    = XW'((64'sd1 <<< (EW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] ErrMin    = XW'(-(64'sd1 <<< (EW - 1)));
  localparam logic signed [XW-1:0] FullScale = XW'(64'sd255 <<< FRAC_BITS);

  function automatic logic signed [EW-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [EW-1:0] r;
    if (v > ErrMax) begin
      r = ErrMax[EW-1:0];
    end else if (v < ErrMin) begin
      r = ErrMin[EW-1:0];
    end else begin
      r = v[EW-1:0];
    end
    return r;
  endfunction

  logic signed [EW-1:0] carry_q, pbl_q, pb_q;
  logic                 first_q;

  logic signed [EW-1:0] carry_eff, pbl_eff, pb_eff, above_eff;
  logic                 first_eff;
  logic signed [XW-1:0] pix_fx;
  logic signed [EW-1:0] sum1, sum, err;
  logic                 dot;
  logic signed [PW-1:0] e_x, p7, p5, p3;
  logic signed [EW-1:0] s7, s5, s3, s1;
  logic signed [EW-1:0] pbl_new;

  // frame start clears the running error state before this pixel
  assign carry_eff = ctl_i.frame_start ? '0 : carry_q;
  assign pbl_eff   = ctl_i.frame_start ? '0 : pbl_q;
  assign pb_eff    = ctl_i.frame_start ? '0 : pb_q;
  assign first_eff = ctl_i.frame_start | first_q;
  assign above_eff = first_eff ? '0 : above_i;

  assign pix_fx = $signed({{(XW - PixW){1'b0}}, pixel_i}) <<< FRAC_BITS;
  assign sum1   = sat(pix_fx + XW'(carry_eff));
  assign sum    = sat(XW'(sum1) + XW'(above_eff));
  assign dot    = (XW'(sum) <<< 1) > FullScale;
  assign err    = sat(dot ? (XW'(sum) - FullScale) : XW'(sum));

  // shares of e*k/16, floored
  assign e_x = PW'(err);
  assign p7  = (e_x <<< 3) - e_x;
  assign p5  = (e_x <<< 2) + e_x;
  assign p3  = (e_x <<< 1) + e_x;
  assign s7  = EW'(p7 >>> 4);
  assign s5  = EW'(p5 >>> 4);
  assign s3  = EW'(p3 >>> 4);
  assign s1  = EW'(e_x >>> 4);

  assign pbl_new = sat(XW'(pb_eff) + XW'(s5));

  assign dot_o    = dot;
  assign a_en_o   = valid_i && (col_i != '0);
  assign a_addr_o = col_i - AW'(1);
  assign a_data_o = sat(XW'(pbl_eff) + XW'(s3));
  assign b_en_o   = valid_i && ctl_i.last;
  assign b_addr_o = col_i;
  assign b_data_o = pbl_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      pbl_q   <= '0;
      pb_q    <= '0;
      first_q <= 1'b1;
    end else if (valid_i) begin
      if (ctl_i.last) begin
        carry_q <= '0;
        pbl_q   <= '0;
        pb_q    <= '0;
        first_q <= 1'b0;
      end else begin
        carry_q <= s7;
        pbl_q   <= pbl_new;
        pb_q    <= s1;
        first_q <= first_eff;
      end
    end
  end

endmodule

// ----- hw/rtl/edd_out_fifo.sv -----
// small result queue between the error datapath and the output channel
// depends on edd_pkg
module edd_out_fifo (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  input  edd_pkg::edd_res_t                      data_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output edd_pkg::edd_res_t                      data_o,
  output logic [$clog2(edd_pkg::OutDepth+1)-1:0] count_o
);
  import edd_pkg::*;

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  edd_res_t        fifo_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = fifo_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/error_diffusion_dither_core.sv -----
// error diffusion dither, one grey pixel word in, one dot word out
// path: a taken pixel word is registered in the datapath stage, then its dot word is queued and offered
// throughput: one word per cycle unless stalled; row memory does one read and one write a cycle
// stalls: input waits while four words sit in the datapath stage and result queue
// reset: row memory is not cleared; a fill count makes unwritten entries read zero
// depends on edd_pkg, edd_if, edd_row_store, edd_diffuse, edd_out_fifo
module error_diffusion_dither_core #(
  parameter int unsigned MAX_LINE  = edd_pkg::MaxLineDef,
  parameter int unsigned FRAC_BITS = edd_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [edd_pkg::CfgW-1:0]  cfg_data_i,
  edd_pix_if.sink                   pix_i,
  edd_dot_if.source                 dot_o
);
  import edd_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_LINE);
  localparam int unsigned EW   = FRAC_BITS + 10;
  localparam int unsigned LW   = (CfgW > AW + 1) ? CfgW : AW + 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  logic [CfgW-1:0] len_q;
  logic [LW-1:0]   len_ext, len_eff;
  logic            accept;

  logic [AW-1:0]   col_d, col_q;
  logic [AW-1:0]   c;
  logic            last;

  logic            s1_valid_q;
  edd_ctl_t        s1_ctl_q;
  logic [AW-1:0]   s1_col_q;
  logic [PixW-1:0] s1_pix_q;

  logic signed [EW-1:0] above;
  logic                 dot;
  logic                 a_en, b_en;
  logic [AW-1:0]        a_addr, b_addr;
  logic signed [EW-1:0] a_data, b_data;

  edd_res_t        res_in, res_out;
  logic [CntW-1:0] fifo_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenRst;
    end else if (cfg_we_i) begin
      len_q <= cfg_data_i;
    end
  end

  assign len_ext = LW'(len_q);

  always_comb begin
    len_eff = len_ext;
    if (len_ext == '0) begin
      len_eff = LW'(1);
    end else if (len_ext > LW'(MAX_LINE)) begin
      len_eff = LW'(MAX_LINE);
    end
  end

  // room for everything in flight keeps the datapath free of stalls
  assign pix_i.ready = ({1'b0, fifo_cnt} + {{CntW{1'b0}}, s1_valid_q})
                       < (CntW + 1)'(OutDepth);
  assign accept      = pix_i.valid && pix_i.ready;

  assign c     = pix_i.frame_start ? '0 : col_q;
  assign last  = (LW'(c) + LW'(1)) >= len_eff;
  assign col_d = last ? '0 : AW'(LW'(c) + LW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q <= '{frame_start: pix_i.frame_start, last: last};
      s1_col_q <= c;
      s1_pix_q <= pix_i.pixel;
    end
  end

  edd_row_store #(
    .DEPTH (MAX_LINE),
    .ERR_W (EW)
  ) u_row_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (c),
    .a_en_i    (a_en),
    .a_addr_i  (a_addr),
    .a_data_i  (a_data),
    .b_en_i    (b_en),
    .b_addr_i  (b_addr),
    .b_data_i  (b_data),
    .above_o   (above)
  );

  edd_diffuse #(
    .DEPTH     (MAX_LINE),
    .FRAC_BITS (FRAC_BITS)
  ) u_diffuse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid_q),
    .ctl_i    (s1_ctl_q),
    .col_i    (s1_col_q),
    .pixel_i  (s1_pix_q),
    .above_i  (above),
    .dot_o    (dot),
    .a_en_o   (a_en),
    .a_addr_o (a_addr),
    .a_data_o (a_data),
    .b_en_o   (b_en),
    .b_addr_o (b_addr),
    .b_data_o (b_data)
  );

  assign res_in = '{dot: dot, line_end: s1_ctl_q.last};

  edd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .data_i  (res_in),
    .valid_o (dot_o.valid),
    .ready_i (dot_o.ready),
    .data_o  (res_out),
    .count_o (fifo_cnt)
  );

  assign dot_o.dot      = res_out.dot;
  assign dot_o.line_end = res_out.line_end;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   s1_valid_q |-> (fifo_cnt < CntW'(OutDepth)))
    else $error("result queue full while a word is being pushed");
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> s1_valid_q)
    else $error("accepted word missing from the datapath stage");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept && last) |=> (col_q == '0))
    else $error("column not reset after end of line");
`endif

endmodule

// ----- verif/error_diffusion_dither_core_tb.sv -----
// testbench for error_diffusion_dither_core: random pixel words against a fixed-point
// dither predictor held in a scoreboard class, with random stalls on both streams
// depends on edd_pkg, edd_if and the core with its submodules
module error_diffusion_dither_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edd_pkg::*;

  localparam int ErrW      = FracBitsDef + 10;
  localparam int ErrMax    = (1 << (ErrW - 1)) - 1;
  localparam int ErrMin    = -(1 << (ErrW - 1));
  localparam int FullScale = 255 << FracBitsDef;
  localparam int MaxLine   = MaxLineDef;

  typedef logic signed [ErrW-1:0] err_t;

  class dither_scoreboard;
    err_t            row_err [MaxLine];
    err_t            carry_px;
    err_t            pend_left;
    err_t            pend_here;
    int unsigned     col_pos;
    bit              first_line;
    logic [CfgW-1:0] line_len;
    edd_res_t        dot_q [$];
    int              errors;

    function new();
      foreach (row_err[k]) row_err[k] = '0;
      line_len = LenRst;
      errors   = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      carry_px   = '0;
      pend_left  = '0;
      pend_here  = '0;
      col_pos    = 0;
      first_line = 1'b1;
    endfunction

    function int clip(int v);
      if (v > ErrMax) return ErrMax;
      if (v < ErrMin) return ErrMin;
      return v;
    endfunction

    function void note_pixel(logic [PixW-1:0] px, logic fs);
      int       len;
      int       c;
      int       above;
      int       acc;
      int       err;
      int       s7;
      int       s3;
      int       s5;
      int       s1;
      bit       last;
      bit       white;
      edd_res_t r;
      len = int'(line_len);
      if (len == 0) len = 1;
      if (len > MaxLine) len = MaxLine;
      if (fs) restart_frame();
      c = int'(col_pos);
      if (c >= MaxLine) c = MaxLine - 1;
      last  = (c + 1 >= len);
      above = first_line ? 0 : int'(row_err[c]);
      acc   = int'(px) * (1 << FracBitsDef);
      acc   = clip(clip(acc + int'(carry_px)) + above);
      white = (2 * acc > FullScale);
      err   = clip(white ? acc - FullScale : acc);
      s7    = (err * 7) >>> 4;
      s3    = (err * 3) >>> 4;
      s5    = (err * 5) >>> 4;
      s1    = err >>> 4;
      if (c > 0) row_err[c-1] = err_t'(clip(int'(pend_left) + s3));
      pend_left = err_t'(clip(int'(pend_here) + s5));
      pend_here = last ? '0 : err_t'(s1);
      carry_px  = last ? '0 : err_t'(s7);
      if (last) begin
        row_err[c] = pend_left;
        pend_left  = '0;
        pend_here  = '0;
        col_pos    = 0;
        first_line = 1'b0;
      end else begin
        col_pos = c + 1;
      end
      r.dot      = white;
      r.line_end = last;
      dot_q      = {dot_q, r};
    endfunction

    function void check_dot(logic d, logic le);
      edd_res_t want;
      if (dot_q.size() == 0) begin
        $error("unexpected dot word: dot=%0b line_end=%0b", d, le);
        errors++;
        return;
      end
      want = dot_q.pop_front();
      if (want.dot !== d) begin
        $error("dot mismatch: expected %0b, actual %0b", want.dot, d);
        errors++;
      end
      if (want.line_end !== le) begin
        $error("line_end mismatch: expected %0b, actual %0b", want.line_end, le);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_data;

  edd_pix_if pix_bus ();
  edd_dot_if dot_bus ();

  dither_scoreboard sb;

  int unsigned tx_idle;
  int unsigned rx_idle;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  error_diffusion_dither_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_bus),
    .dot_o      (dot_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      dot_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      dot_bus.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && dot_bus.valid && dot_bus.ready) begin
      sb.check_dot(dot_bus.dot, dot_bus.line_end);
    end
  end

  task automatic send_pixel(input logic [PixW-1:0] px, input logic fs);
    while ($urandom_range(99) < tx_idle) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.pixel       <= px;
    pix_bus.frame_start <= fs;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
    sb.note_pixel(px, fs);
  endtask

  task automatic wait_all_dots();
    int unsigned spins;
    spins = 0;
    pix_bus.valid <= 1'b0;
    while (sb.dot_q.size() != 0 && spins < 20000) begin
      @(posedge clk_i);
      spins++;
    end
    if (sb.dot_q.size() != 0) begin
      $error("%0d dot words never arrived", sb.dot_q.size());
      sb.errors += sb.dot_q.size();
      sb.dot_q.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_len(input logic [CfgW-1:0] len);
    wait_all_dots();
    cfg_we   <= 1'b1;
    cfg_data <= len;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.line_len = len;
  endtask

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(3))
      0, 1: return PixW'($urandom_range(255));
      2: begin
        case ($urandom_range(3))
          0: return 8'd0;
          1: return 8'd255;
          2: return 8'd127;
          default: return 8'd128;
        endcase
      end
      default: return PixW'($urandom_range(143, 112));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_len();
    case ($urandom_range(9))
      0: return '0;
      1: return CfgW'(1);
      2: return CfgW'(2047);
      3: return CfgW'(1024);
      default: return CfgW'($urandom_range(24, 2));
    endcase
  endfunction

  task automatic run_phase(input logic [CfgW-1:0] len, input int unsigned n);
    bit fs_first;
    fs_first = 1'($urandom_range(1));
    write_len(len);
    for (int unsigned k = 0; k < n; k++) begin
      send_pixel(pick_pixel(), (k == 0 && fs_first) || ($urandom_range(99) < 2));
    end
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb = new();
    tx_idle   = 9;
    rx_idle   = 79;
    hold_req  = 0;
    hold_seen = 0;
    hold_left = 0;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    pix_bus.valid       = 1'b0;
    pix_bus.pixel       = '0;
    pix_bus.frame_start = 1'b0;
    dot_bus.ready       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, half-scale edge, frame start mid-line, length changes
    write_len(CfgW'(3));
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd127, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd60, 1'b0);
    send_pixel(8'd90, 1'b1);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd250, 1'b0);
    write_len('0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd0, 1'b0);
    write_len(CfgW'(2047));
    send_pixel(8'd100, 1'b1);
    send_pixel(8'd255, 1'b0);
    write_len(CfgW'(1));
    send_pixel(8'd129, 1'b0);
    send_pixel(8'd126, 1'b0);
    write_len(CfgW'(8));
    send_pixel(8'd200, 1'b1);
    send_pixel(8'd33, 1'b0);
    send_pixel(8'd170, 1'b0);
    send_pixel(8'd85, 1'b0);
    send_pixel(8'd240, 1'b0);
    write_len(CfgW'(2));
    send_pixel(8'd15, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);

    repeat (5) run_phase(pick_len(), 10);

    tx_idle = 79;
    rx_idle = 9;
    repeat (5) run_phase(pick_len(), 10);

    tx_idle = 0;
    rx_idle = 0;
    run_phase(CfgW'(1024), 1030);

    write_len(CfgW'(5));
    send_pixel(8'd255, 1'b1);
    hold_req++;
    for (int unsigned k = 0; k < 40; k++) send_pixel(pick_pixel(), 1'b0);
    wait_all_dots();
    for (int unsigned k = 0; k < 20; k++) send_pixel(pick_pixel(), 1'b0);

    repeat (4) run_phase(pick_len(), 10);

    wait_all_dots();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/edd_pkg.sv
hw/rtl/edd_if.sv
hw/rtl/edd_row_store.sv
hw/rtl/edd_diffuse.sv
hw/rtl/edd_out_fifo.sv
hw/rtl/error_diffusion_dither_core.sv
verif/error_diffusion_dither_core_tb.sv
